/* src/bdhr_pkg.sv */
// Shared types and constants for the button debounce / hold / repeat block.
`timescale 1ns / 1ps

package bdhr_pkg;

  // Configuration register widths and reset values
  localparam int CFG_W          = 24;
  localparam int CFG_IDX_W      = 3;
  localparam int OUT_CNT_W      = 8;

  localparam logic [CFG_W-1:0] DEBOUNCE_RST = 24'd20000;
  localparam logic [CFG_W-1:0] HOLD_RST     = 24'd500000;
  localparam logic [CFG_W-1:0] REPEAT_RST   = 24'd100000;
  localparam logic [CFG_W-1:0] IDLE_RST     = 24'd1000000;
  localparam logic             POLARITY_RST = 1'b0;

  // Default sizes handed to the top level parameters
  localparam int COUNT_WIDTH_DEF = 8;
  localparam int TIME_WIDTH_DEF  = 32;

  // Register indexes on the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEBOUNCE    = 3'd0,
    REG_HOLD        = 3'd1,
    REG_REPEAT      = 3'd2,
    REG_IDLE_CLEAR  = 3'd3,
    REG_ACTIVE_HIGH = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [CFG_W-1:0] debounce_ticks;
    logic [CFG_W-1:0] hold_ticks;
    logic [CFG_W-1:0] repeat_ticks;
    logic [CFG_W-1:0] idle_clear_ticks;
    logic             active_high;
  } cfg_t;

  typedef struct packed {
    logic pin_level;
    logic edge_seen;
    logic take_click;
    logic take_repeat;
    logic clear_clicks;
    logic clear_repeats;
  } item_t;

  typedef struct packed {
    logic                 is_pressed;
    logic                 is_held;
    logic [OUT_CNT_W-1:0] clicks_pending;
    logic [OUT_CNT_W-1:0] repeats_pending;
    logic                 click_taken;
    logic                 repeat_taken;
  } result_t;

endpackage

/* src/bdhr_cfg.sv */
// Configuration register file for the debounce / hold / repeat block.
`timescale 1ns / 1ps

module bdhr_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [bdhr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bdhr_pkg::CFG_W-1:0]    cfg_wdata,
  output bdhr_pkg::cfg_t                cfg
);

  bdhr_pkg::cfg_t cfg_r;
  bdhr_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        bdhr_pkg::REG_DEBOUNCE:    cfg_nxt.debounce_ticks   = cfg_wdata;
        bdhr_pkg::REG_HOLD:        cfg_nxt.hold_ticks       = cfg_wdata;
        bdhr_pkg::REG_REPEAT:      cfg_nxt.repeat_ticks     = cfg_wdata;
        bdhr_pkg::REG_IDLE_CLEAR:  cfg_nxt.idle_clear_ticks = cfg_wdata;
        bdhr_pkg::REG_ACTIVE_HIGH: cfg_nxt.active_high      = cfg_wdata[0];
        default:                   cfg_nxt = cfg_r;  // unmapped index: ignored
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ticks   <= bdhr_pkg::DEBOUNCE_RST;
      cfg_r.hold_ticks       <= bdhr_pkg::HOLD_RST;
      cfg_r.repeat_ticks     <= bdhr_pkg::REPEAT_RST;
      cfg_r.idle_clear_ticks <= bdhr_pkg::IDLE_RST;
      cfg_r.active_high      <= bdhr_pkg::POLARITY_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

/* src/bdhr_engine.sv */
// Per-tick state update: debounce, hold detection, auto-repeat, counters.
`timescale 1ns / 1ps

module bdhr_engine #(
  parameter int COUNT_WIDTH = bdhr_pkg::COUNT_WIDTH_DEF,
  parameter int TIME_WIDTH  = bdhr_pkg::TIME_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  bdhr_pkg::item_t   item,
  input  bdhr_pkg::cfg_t    cfg,
  output bdhr_pkg::result_t res
);

  // compare width covers both the time difference and a 24-bit limit
  localparam int CmpW = (TIME_WIDTH > bdhr_pkg::CFG_W) ? TIME_WIDTH : bdhr_pkg::CFG_W;
  localparam int OutW = bdhr_pkg::OUT_CNT_W;

  typedef logic [TIME_WIDTH-1:0]  time_t;
  typedef logic [COUNT_WIDTH-1:0] cnt_t;

  function automatic logic reached(input time_t dt, input logic [bdhr_pkg::CFG_W-1:0] lim);
    logic [CmpW+TIME_WIDTH-1:0]      a;
    logic [CmpW+bdhr_pkg::CFG_W-1:0] b;
    a = {{CmpW{1'b0}}, dt};
    b = {{CmpW{1'b0}}, lim};
    return a[CmpW-1:0] >= b[CmpW-1:0];
  endfunction

  function automatic cnt_t sat_inc(input cnt_t c);
    return (&c) ? c : c + COUNT_WIDTH'(1);
  endfunction

  time_t now_r, now_nxt;
  logic  armed_r, armed_nxt;
  time_t edge_time_r, edge_time_nxt;
  logic  level_r, level_nxt;
  cnt_t  click_r, click_nxt;
  logic  hold_pend_r, hold_pend_nxt;
  logic  hold_act_r, hold_act_nxt;
  cnt_t  rep_r, rep_nxt;
  time_t press_r, press_nxt;
  time_t last_rep_r, last_rep_nxt;
  time_t clr_time_r, clr_time_nxt;

  logic  disarm, sample, new_press, hold_fire, rep_fire, idle_fire;
  logic  deb_hit, hold_hit;
  logic  hold_pend1, hold_act1;
  cnt_t  click1, rep1;
  logic  click_taken, repeat_taken;
  logic [COUNT_WIDTH+OutW-1:0] click_ext, rep_ext;

  always_comb begin
    // edge while armed: disarm and timestamp (elapsed since then is zero)
    disarm        = armed_r & item.edge_seen;
    edge_time_nxt = disarm ? now_r : edge_time_r;
    deb_hit       = disarm ? (cfg.debounce_ticks == '0)
                           : reached(now_r - edge_time_r, cfg.debounce_ticks);
    sample        = (~armed_r | disarm) & deb_hit;
    armed_nxt     = (armed_r & ~disarm) | sample;

    level_nxt  = sample ? (cfg.active_high ? item.pin_level : ~item.pin_level) : level_r;
    new_press  = sample & level_nxt;
    click1     = new_press ? sat_inc(click_r) : click_r;
    press_nxt  = new_press ? now_r : press_r;
    hold_act1  = (sample & ~level_nxt) ? 1'b0 : hold_act_r;
    hold_pend1 = sample ? level_nxt : hold_pend_r;

    // hold timer, elapsed zero on the tick of the press
    hold_hit      = new_press ? (cfg.hold_ticks == '0)
                              : reached(now_r - press_r, cfg.hold_ticks);
    hold_fire     = hold_pend1 & hold_hit;
    hold_pend_nxt = hold_pend1 & ~hold_fire;
    hold_act_nxt  = hold_act1 | hold_fire;

    // auto-repeat while held, idle clear otherwise
    rep_fire  = hold_act_nxt & reached(now_r - last_rep_r, cfg.repeat_ticks);
    idle_fire = ~hold_act_nxt & (rep_r != '0) &
                reached(now_r - clr_time_r, cfg.idle_clear_ticks);
    rep1         = rep_r;
    last_rep_nxt = last_rep_r;
    clr_time_nxt = clr_time_r;
    if (rep_fire) begin
      rep1         = sat_inc(rep_r);
      last_rep_nxt = now_r;
      clr_time_nxt = now_r;
    end else if (idle_fire) begin
      rep1         = '0;
      clr_time_nxt = now_r;
    end

    // takes first, then clears
    click_taken  = item.take_click & (click1 != '0);
    repeat_taken = item.take_repeat & (rep1 != '0);
    click_nxt    = click_taken ? click1 - COUNT_WIDTH'(1) : click1;
    rep_nxt      = repeat_taken ? rep1 - COUNT_WIDTH'(1) : rep1;
    if (item.clear_clicks) click_nxt = '0;
    if (item.clear_repeats) rep_nxt = '0;

    now_nxt = now_r + TIME_WIDTH'(1);

    click_ext = {{OutW{1'b0}}, click_nxt};
    rep_ext   = {{OutW{1'b0}}, rep_nxt};

    res.is_pressed      = level_nxt;
    res.is_held         = hold_act_nxt;
    res.clicks_pending  = click_ext[OutW-1:0];
    res.repeats_pending = rep_ext[OutW-1:0];
    res.click_taken     = click_taken;
    res.repeat_taken    = repeat_taken;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      now_r       <= '0;
      armed_r     <= 1'b0;
      edge_time_r <= '0;
      level_r     <= 1'b0;
      click_r     <= '0;
      hold_pend_r <= 1'b0;
      hold_act_r  <= 1'b0;
      rep_r       <= '0;
      press_r     <= '0;
      last_rep_r  <= '0;
      clr_time_r  <= '0;
    end else if (step) begin
      now_r       <= now_nxt;
      armed_r     <= armed_nxt;
      edge_time_r <= edge_time_nxt;
      level_r     <= level_nxt;
      click_r     <= click_nxt;
      hold_pend_r <= hold_pend_nxt;
      hold_act_r  <= hold_act_nxt;
      rep_r       <= rep_nxt;
      press_r     <= press_nxt;
      last_rep_r  <= last_rep_nxt;
      clr_time_r  <= clr_time_nxt;
    end
  end

endmodule

/* src/button_debounce_hold_repeat_core.sv */
// Top level: button debouncer with hold detection and auto-repeat.
`timescale 1ns / 1ps

// Channel   Handshake              Payload
// -------   --------------------   ------------------------------------------
// in_       in_valid / in_ready    pin_level, edge_seen, take/clear requests
// out_      out_valid / out_ready  is_pressed, is_held, counts, taken flags
// cfg_      cfg_we (no wait)       cfg_index, cfg_wdata (24 bit)
//
// One transaction per clock sustained while out_ready stays high. A tick lands
// in the input register, and its state update runs as combinational logic into
// the result register. All control and tick state is cleared by synchronous
// reset; the time base restarts at zero. A stalled result holds in the output
// register while the input register keeps one more tick; both stall only when
// out_ready stays low.

module button_debounce_hold_repeat_core #(
  parameter int COUNT_WIDTH = bdhr_pkg::COUNT_WIDTH_DEF,
  parameter int TIME_WIDTH  = bdhr_pkg::TIME_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // tick input
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_pin_level,
  input  logic                           in_edge_seen,
  input  logic                           in_take_click,
  input  logic                           in_take_repeat,
  input  logic                           in_clear_clicks,
  input  logic                           in_clear_repeats,
  // result output
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_is_pressed,
  output logic                           out_is_held,
  output logic [bdhr_pkg::OUT_CNT_W-1:0] out_clicks_pending,
  output logic [bdhr_pkg::OUT_CNT_W-1:0] out_repeats_pending,
  output logic                           out_click_taken,
  output logic                           out_repeat_taken,
  // configuration writes
  input  logic                           cfg_we,
  input  logic [bdhr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bdhr_pkg::CFG_W-1:0]     cfg_wdata
);

  bdhr_pkg::cfg_t    cfg;
  bdhr_pkg::item_t   in_item;
  bdhr_pkg::item_t   item_r;
  bdhr_pkg::result_t res;
  bdhr_pkg::result_t res_r;

  logic in_valid_r, in_valid_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_free, step, in_take;

  // result slot free when empty or being drained this cycle
  assign out_free = ~out_valid_r | out_ready;
  assign step     = in_valid_r & out_free;
  assign in_ready = ~in_valid_r | step;
  assign in_take  = in_valid & in_ready;

  assign in_valid_nxt  = in_take | (in_valid_r & ~step);
  assign out_valid_nxt = step | (out_valid_r & ~out_ready);

  assign in_item.pin_level     = in_pin_level;
  assign in_item.edge_seen     = in_edge_seen;
  assign in_item.take_click    = in_take_click;
  assign in_item.take_repeat   = in_take_repeat;
  assign in_item.clear_clicks  = in_clear_clicks;
  assign in_item.clear_repeats = in_clear_repeats;

  bdhr_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  bdhr_engine #(
    .COUNT_WIDTH (COUNT_WIDTH),
    .TIME_WIDTH  (TIME_WIDTH)
  ) u_engine (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .item  (item_r),
    .cfg   (cfg),
    .res   (res)
  );

  // handshake state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r <= in_item;
    end
    if (step) begin
      res_r <= res;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_is_pressed      = res_r.is_pressed;
  assign out_is_held         = res_r.is_held;
  assign out_clicks_pending  = res_r.clicks_pending;
  assign out_repeats_pending = res_r.repeats_pending;
  assign out_click_taken     = res_r.click_taken;
  assign out_repeat_taken    = res_r.repeat_taken;

endmodule

/* tb/button_status_checker.sv */
// Checker for the button debounce core: predicts each tick's status and compares it.
`timescale 1ns / 1ps

module button_status_checker
  import bdhr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic                 in_pin_level,
  input  logic                 in_edge_seen,
  input  logic                 in_take_click,
  input  logic                 in_take_repeat,
  input  logic                 in_clear_clicks,
  input  logic                 in_clear_repeats,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic                 out_is_pressed,
  input  logic                 out_is_held,
  input  logic [OUT_CNT_W-1:0] out_clicks_pending,
  input  logic [OUT_CNT_W-1:0] out_repeats_pending,
  input  logic                 out_click_taken,
  input  logic                 out_repeat_taken,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  output int                   errors,
  output int                   outstanding
);

  localparam int PRINT_CAP = 40;
  localparam logic [COUNT_WIDTH_DEF-1:0] COUNT_TOP = '1;

  cfg_t                       cfg_q;
  logic [TIME_WIDTH_DEF-1:0]  tick_now, edge_at, press_at, repeat_at, idle_from;
  logic                       armed_q, pressed_q, hold_wait_q, held_q;
  logic [COUNT_WIDTH_DEF-1:0] clicks_q, repeats_q;
  result_t                    awaited_status[$];

  task automatic report_mismatch(input string msg);
    if (errors < PRINT_CAP) begin
      $display("[%0t] checker: %s", $time, msg);
    end
    errors++;
  endtask

  function automatic logic [COUNT_WIDTH_DEF-1:0] bump(input logic [COUNT_WIDTH_DEF-1:0] c);
    return (c == COUNT_TOP) ? c : c + 1'b1;
  endfunction

  // One tick of the debouncer: edge, sampling, hold, repeat/idle clear, takes, clears.
  function automatic result_t advance_button_model(input item_t it);
    result_t                   r;
    logic [TIME_WIDTH_DEF-1:0] t;
    logic                      took_click, took_repeat;
    t           = tick_now;
    took_click  = 1'b0;
    took_repeat = 1'b0;

    if (armed_q && it.edge_seen) begin
      armed_q = 1'b0;
      edge_at = t;
    end

    if (!armed_q && (t - edge_at) >= cfg_q.debounce_ticks) begin
      armed_q   = 1'b1;
      pressed_q = cfg_q.active_high ? it.pin_level : !it.pin_level;
      if (pressed_q) begin
        clicks_q = bump(clicks_q);
        press_at = t;
      end else begin
        held_q = 1'b0;
      end
      hold_wait_q = pressed_q;
    end

    if (hold_wait_q && (t - press_at) >= cfg_q.hold_ticks) begin
      hold_wait_q = 1'b0;
      held_q      = 1'b1;
    end

    if (held_q) begin
      if ((t - repeat_at) >= cfg_q.repeat_ticks) begin
        repeats_q = bump(repeats_q);
        repeat_at = t;
        idle_from = t;
      end
    end else if (repeats_q != 0 && (t - idle_from) >= cfg_q.idle_clear_ticks) begin
      repeats_q = '0;
      idle_from = t;
    end

    // take first, then clear
    if (it.take_click && clicks_q != 0) begin
      clicks_q--;
      took_click = 1'b1;
    end
    if (it.take_repeat && repeats_q != 0) begin
      repeats_q--;
      took_repeat = 1'b1;
    end
    if (it.clear_clicks)  clicks_q  = '0;
    if (it.clear_repeats) repeats_q = '0;

    tick_now = t + 1'b1;

    r.is_pressed      = pressed_q;
    r.is_held         = held_q;
    r.clicks_pending  = clicks_q;
    r.repeats_pending = repeats_q;
    r.click_taken     = took_click;
    r.repeat_taken    = took_repeat;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    item_t   it;
    result_t got, want;
    if (!rst_n) begin
      cfg_q.debounce_ticks   = DEBOUNCE_RST;
      cfg_q.hold_ticks       = HOLD_RST;
      cfg_q.repeat_ticks     = REPEAT_RST;
      cfg_q.idle_clear_ticks = IDLE_RST;
      cfg_q.active_high      = POLARITY_RST;
      tick_now    = '0;
      edge_at     = '0;
      press_at    = '0;
      repeat_at   = '0;
      idle_from   = '0;
      armed_q     = 1'b0;
      pressed_q   = 1'b0;
      hold_wait_q = 1'b0;
      held_q      = 1'b0;
      clicks_q    = '0;
      repeats_q   = '0;
      awaited_status.delete();
    end else begin
      if (cfg_we) begin
        case (reg_idx_t'(cfg_index))
          REG_DEBOUNCE:    cfg_q.debounce_ticks   = cfg_wdata;
          REG_HOLD:        cfg_q.hold_ticks       = cfg_wdata;
          REG_REPEAT:      cfg_q.repeat_ticks     = cfg_wdata;
          REG_IDLE_CLEAR:  cfg_q.idle_clear_ticks = cfg_wdata;
          REG_ACTIVE_HIGH: cfg_q.active_high      = cfg_wdata[0];
          default: ;
        endcase
      end

      if (in_valid && in_ready) begin
        it.pin_level     = in_pin_level;
        it.edge_seen     = in_edge_seen;
        it.take_click    = in_take_click;
        it.take_repeat   = in_take_repeat;
        it.clear_clicks  = in_clear_clicks;
        it.clear_repeats = in_clear_repeats;
        awaited_status.push_back(advance_button_model(it));
      end

      if (out_valid && out_ready) begin
        got.is_pressed      = out_is_pressed;
        got.is_held         = out_is_held;
        got.clicks_pending  = out_clicks_pending;
        got.repeats_pending = out_repeats_pending;
        got.click_taken     = out_click_taken;
        got.repeat_taken    = out_repeat_taken;
        if (awaited_status.size() == 0) begin
          report_mismatch("status transaction with no tick awaiting it");
        end else begin
          want = awaited_status.pop_front();
          if (got.is_pressed !== want.is_pressed)
            report_mismatch($sformatf("is_pressed: expected %b, got %b",
                                      want.is_pressed, got.is_pressed));
          if (got.is_held !== want.is_held)
            report_mismatch($sformatf("is_held: expected %b, got %b",
                                      want.is_held, got.is_held));
          if (got.clicks_pending !== want.clicks_pending)
            report_mismatch($sformatf("clicks_pending: expected %0d, got %0d",
                                      want.clicks_pending, got.clicks_pending));
          if (got.repeats_pending !== want.repeats_pending)
            report_mismatch($sformatf("repeats_pending: expected %0d, got %0d",
                                      want.repeats_pending, got.repeats_pending));
          if (got.click_taken !== want.click_taken)
            report_mismatch($sformatf("click_taken: expected %b, got %b",
                                      want.click_taken, got.click_taken));
          if (got.repeat_taken !== want.repeat_taken)
            report_mismatch($sformatf("repeat_taken: expected %b, got %b",
                                      want.repeat_taken, got.repeat_taken));
        end
      end
    end
    outstanding = awaited_status.size();
  end

endmodule

/* tb/button_debounce_hold_repeat_core_tb.sv */
// Testbench top for the button debounce / hold / repeat core: stimulus and verdict.
`timescale 1ns / 1ps

module button_debounce_hold_repeat_core_tb;
  import bdhr_pkg::*;

  localparam int HALF_PERIOD_NS = 6;     // 12 ns clock
  localparam int RESET_CYCLES   = 12;
  localparam int SETTLE_CYCLES  = 4;     // idle gap before register writes
  localparam int TAIL_CYCLES    = 8;     // quiet time after the last status transaction
  localparam int HOLDOFF_CYCLES = 60;    // long output stall, fills both core registers
  localparam int STALL_LIMIT    = 2000;  // cycles without any transaction before giving up
  localparam logic [CFG_W-1:0] FULL_SCALE = '1;

  // Where each phase gets its ticks from
  typedef enum int {
    SRC_SCRIPT,    // hand-written list
    SRC_BUTTON,    // bouncing button presses with random requests
    SRC_NOISE,     // all six input bits random
    SRC_SATURATE   // press held, edge every tick, almost no takes: drives counts to the top
  } tick_source_t;

  logic                 clk              = 1'b0;
  logic                 rst_n            = 1'b0;
  logic                 in_valid         = 1'b0;
  logic                 in_ready;
  logic                 in_pin_level     = 1'b0;
  logic                 in_edge_seen     = 1'b0;
  logic                 in_take_click    = 1'b0;
  logic                 in_take_repeat   = 1'b0;
  logic                 in_clear_clicks  = 1'b0;
  logic                 in_clear_repeats = 1'b0;
  logic                 out_valid;
  logic                 out_ready        = 1'b0;
  logic                 out_is_pressed;
  logic                 out_is_held;
  logic [OUT_CNT_W-1:0] out_clicks_pending;
  logic [OUT_CNT_W-1:0] out_repeats_pending;
  logic                 out_click_taken;
  logic                 out_repeat_taken;
  logic                 cfg_we           = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index        = '0;
  logic [CFG_W-1:0]     cfg_wdata        = '0;

  int     mismatches;
  int     awaiting;
  int     send_idle_pct = 0;
  int     recv_idle_pct = 0;
  bit     holdoff_req   = 1'b0;
  int     ticks_sent    = 0;
  int     phases_run    = 0;
  int     quiet_cycles  = 0;

  // button generator state
  bit     phys_pin    = 1'b0;
  bit     last_pin    = 1'b0;
  int     bounce_left = 0;
  item_t  script[$];

  button_debounce_hold_repeat_core u_top (.*);

  button_status_checker u_checker (
    .errors      (mismatches),
    .outstanding (awaiting),
    .*
  );

  always #HALF_PERIOD_NS clk = ~clk;

  // Watchdog: any transaction on either channel restarts the count.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("no transaction for %0d cycles, %0d ticks still awaited",
                 STALL_LIMIT, awaiting);
        $display("button_debounce_hold_repeat_core_tb: FAIL");
        $finish;
      end
    end
  end

  // Status receiver: random back-pressure, or a long hold-off on request.
  // The hold-off is counted here so the sender keeps offering ticks meanwhile.
  initial begin
    forever begin
      @(negedge clk);
      if (holdoff_req) begin
        out_ready = 1'b0;
        repeat (HOLDOFF_CYCLES) @(negedge clk);
        holdoff_req = 1'b0;
      end else begin
        out_ready = ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  function automatic item_t make_tick(input bit pin, input bit toggled, input bit take_c,
                                      input bit take_r, input bit clr_c, input bit clr_r);
    return item_t'({pin, toggled, take_c, take_r, clr_c, clr_r});
  endfunction

  function automatic item_t next_tick(input tick_source_t src);
    item_t      it;
    logic [5:0] raw;
    raw = $urandom_range(63);
    it  = raw;
    case (src)
      SRC_SCRIPT: begin
        it = script.pop_front();
      end
      SRC_NOISE: ;
      SRC_SATURATE: begin
        // pressed level for active-high; an edge every tick resamples with zero
        // debounce, so each tick counts a click and an increment
        it.pin_level     = 1'b1;
        it.edge_seen     = 1'b1;
        it.take_click    = ($urandom_range(99) < 1);
        it.take_repeat   = ($urandom_range(99) < 1);
        it.clear_clicks  = 1'b0;
        it.clear_repeats = 1'b0;
      end
      default: begin
        // occasional garbage tick inside the button stream
        if ($urandom_range(99) >= 6) begin
          if (bounce_left > 0) begin
            // contact bounce: random level, edge when it moves
            it.pin_level = $urandom_range(1);
            bounce_left--;
            if (bounce_left == 0) it.pin_level = phys_pin;
            it.edge_seen = (it.pin_level != last_pin) || ($urandom_range(9) == 0);
          end else if ($urandom_range(13) == 0) begin
            phys_pin     = !phys_pin;
            it.pin_level = phys_pin;
            it.edge_seen = 1'b1;
            bounce_left  = $urandom_range(3);
          end else begin
            it.pin_level = phys_pin;
            it.edge_seen = ($urandom_range(49) == 0);
          end
          it.take_click    = ($urandom_range(99) < 12);
          it.take_repeat   = ($urandom_range(99) < 15);
          it.clear_clicks  = ($urandom_range(99) < 3);
          it.clear_repeats = ($urandom_range(99) < 3);
          last_pin = it.pin_level;
        end
      end
    endcase
    return it;
  endfunction

  // Offer one tick, optionally after idle cycles; returns at the next falling edge
  // once accepted. Valid stays high across back-to-back ticks.
  task automatic send_tick(input item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid         = 1'b1;
    in_pin_level     = it.pin_level;
    in_edge_seen     = it.edge_seen;
    in_take_click    = it.take_click;
    in_take_repeat   = it.take_repeat;
    in_clear_clicks  = it.clear_clicks;
    in_clear_repeats = it.clear_repeats;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    ticks_sent++;
    @(negedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [CFG_W-1:0] value);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = value;
    @(negedge clk);
  endtask

  // Drain, reprogram all registers while the core is idle, then stream ticks.
  task automatic run_phase(input logic [CFG_W-1:0] debounce, input logic [CFG_W-1:0] hold,
                           input logic [CFG_W-1:0] rpt, input logic [CFG_W-1:0] idle_clr,
                           input bit pol, input int n, input tick_source_t src,
                           input bit hold_off);
    wait (awaiting == 0);
    @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    write_reg(REG_DEBOUNCE, debounce);
    write_reg(REG_HOLD, hold);
    write_reg(REG_REPEAT, rpt);
    write_reg(REG_IDLE_CLEAR, idle_clr);
    write_reg(REG_ACTIVE_HIGH, CFG_W'(pol));
    cfg_we = 1'b0;
    phases_run++;
    if (hold_off) holdoff_req = 1'b1;
    for (int i = 0; i < n; i++) send_tick(next_tick(src));
    in_valid = 1'b0;
  endtask

  initial begin
    // single synchronous reset at the start
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n = 1'b1;

    // sender sparse gaps, receiver mostly stalled
    send_idle_pct = 7;
    recv_idle_pct = 66;

    // Directed, active-high: not armed after reset so the pin is first sampled
    // three ticks in; zero repeat period; take and clear together.
    script.push_back(make_tick(1, 0, 0, 0, 0, 0));  // before first sample
    script.push_back(make_tick(1, 1, 0, 0, 0, 0));  // edge while not armed: ignored
    script.push_back(make_tick(0, 0, 1, 1, 0, 0));  // takes on empty counts
    repeat (3) script.push_back(make_tick(1, 0, 0, 0, 0, 0));  // press, then hold
    script.push_back(make_tick(1, 0, 0, 1, 0, 0));  // take one increment
    script.push_back(make_tick(1, 0, 1, 0, 1, 0));  // take click and clear clicks
    script.push_back(make_tick(1, 0, 0, 1, 0, 1));  // take increment and clear them
    script.push_back(make_tick(1, 0, 0, 0, 0, 0));
    script.push_back(make_tick(0, 1, 0, 0, 0, 0));  // release edge, disarm
    script.push_back(make_tick(1, 1, 0, 0, 0, 0));  // bounce during debounce
    repeat (6) script.push_back(make_tick(0, 0, 0, 0, 0, 0));  // release sampled, idle clear
    script.push_back(make_tick(1, 1, 1, 1, 1, 1));  // every bit high
    script.push_back(make_tick(0, 0, 0, 0, 0, 0));  // every bit low
    run_phase(24'd3, 24'd2, 24'd0, 24'd4, 1'b1, script.size(), SRC_SCRIPT, 1'b0);

    // Directed, active-low: zero debounce and zero hold time, press holds at once;
    // zero idle clear drops increments on the release tick.
    script.push_back(make_tick(0, 1, 0, 0, 0, 0));
    script.push_back(make_tick(0, 0, 0, 0, 0, 0));
    script.push_back(make_tick(1, 1, 0, 0, 0, 0));
    script.push_back(make_tick(1, 0, 1, 1, 0, 0));
    script.push_back(make_tick(0, 1, 1, 0, 0, 0));
    run_phase(24'd0, 24'd0, 24'd7, 24'd0, 1'b0, script.size(), SRC_SCRIPT, 1'b0);

    run_phase(24'd2, 24'd8, 24'd3, 24'd10, 1'b1, 120, SRC_BUTTON, 1'b0);
    run_phase(24'd0, 24'd0, 24'd1, 24'd0, 1'b0, 60, SRC_NOISE, 1'b0);

    // sender mostly idle, receiver nearly always ready
    send_idle_pct = 66;
    recv_idle_pct = 7;
    run_phase(24'd5, 24'd12, 24'd4, 24'd30, 1'b0, 100, SRC_BUTTON, 1'b0);
    // full-scale timings: nothing rearms, hold never starts, no idle clear
    run_phase(FULL_SCALE, FULL_SCALE, FULL_SCALE, FULL_SCALE, 1'b1, 30, SRC_BUTTON, 1'b0);

    // no idling on either side; long output hold-off at the start of the saturation run
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_phase(24'd0, 24'd0, 24'd1, FULL_SCALE, 1'b1, 270, SRC_SATURATE, 1'b1);
    run_phase(24'd1, 24'd3, 24'd0, 24'd5, 1'b0, 80, SRC_BUTTON, 1'b0);

    wait (awaiting == 0);
    @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("%0d ticks over %0d register settings: both polarities, zero and full-scale timings",
             ticks_sent, phases_run);
    $display("click and increment counts pushed to saturation; output held off %0d cycles",
             HOLDOFF_CYCLES);
    if (mismatches == 0) begin
      $display("button_debounce_hold_repeat_core_tb: PASS");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("button_debounce_hold_repeat_core_tb: FAIL");
    end
    $finish;
  end

endmodule
